[rtl/core/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the signed radix to text converter: register
// indexes, fixed field widths, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srt_pkg;

    // Fixed widths of the channel fields.
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int RADIX_W    = 5;

    // Dividend bits consumed by the divider in one cycle.
    localparam int DIV_STEP_BITS = 8;

    // Characters per alphabet word and bits of a digit code.
    localparam int ALPHA_CHARS = 8;
    localparam int DIGIT_CODE_W = 4;

    localparam logic [CHAR_W-1:0]  SIGN_CHAR   = 8'h2D;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HI = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PREP,
        ST_SIGN,
        ST_DIGITS
    } srt_state_t;

    typedef struct packed {
        logic load;        // take a new value into the divider
        logic step;        // run one divider step
        logic prep;        // point the read side at the top digit
        logic emit_sign;   // load the minus sign into the output register
        logic emit_digit;  // load the current digit character
    } srt_cmd_t;

    typedef struct packed {
        logic step_last;   // this divider cycle finishes a digit
        logic quot_zero;   // the quotient after this cycle is zero
        logic neg;         // the value being converted is negative
        logic ptr_zero;    // the digit being emitted is the lowest one
        logic out_free;    // the output register can take a character
    } srt_stat_t;

endpackage

[rtl/core/srt_if.sv]
// ----------------------------------------------------------------------------
// srt_if
// Valid/ready channel interfaces: the integer input, the character output
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface srt_num_if
    import srt_pkg::*;
#(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface srt_txt_if
    import srt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface srt_cfg_if
    import srt_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/signed_radix_to_text.sv]
// ----------------------------------------------------------------------------
// signed_radix_to_text
// Converts a signed integer into its text in a configurable radix, one
// character per output beat, most significant first, with a leading minus
// sign for negative values and the last character of each number flagged.
// ----------------------------------------------------------------------------
// Sequence: the value is accepted, the divider runs over the whole magnitude
// once per digit, a read setup state points at the top digit, and then the
// optional minus sign and the digits are loaded into the output register,
// each waiting while the output is stalled. A new value is accepted only
// once the last character has been loaded into the output register.
// Reset: asynchronous, active low. It returns the controller to idle, drops
// the output valid and restores radix 10 and an all-zero alphabet.
// ----------------------------------------------------------------------------
module signed_radix_to_text
    import srt_pkg::*;
#(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
)(
    input  logic      clk,
    input  logic      rst_n,
    srt_num_if.sink   num,
    srt_txt_if.source txt,
    srt_cfg_if.sink   cfg
);
    localparam int RAD_W = $clog2(MAX_RADIX) + 1;

    // The controller and the datapath see each other only through these
    // two bundles.
    srt_cmd_t  cmd;
    srt_stat_t stat;

    logic [RAD_W-1:0]      active_radix;
    logic [CFG_DATA_W-1:0] digits_lo;
    logic [CFG_DATA_W-1:0] digits_hi;

    // Configuration registers. Writes are always taken; they are expected
    // only while no conversion is in flight.
    srt_cfg_regs #(
        .MAX_RADIX (MAX_RADIX)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_valid     (cfg.valid),
        .wr_ready     (cfg.ready),
        .wr_index     (cfg.index),
        .wr_data      (cfg.data),
        .active_radix (active_radix),
        .digits_lo    (digits_lo),
        .digits_hi    (digits_hi)
    );

    // The controller accepts a new value only in its idle state. It walks
    // through the division phase, a read setup state, the optional sign beat
    // and finally the digit beats.
    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (num.valid),
        .in_ready (num.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the divider, the digit store and the output
    // register. Because the output register holds the final beat on its
    // own, the next value can be accepted while that beat is still waiting
    // to be taken downstream.
    srt_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RADIX  (MAX_RADIX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .value        (num.value),
        .active_radix (active_radix),
        .digits_lo    (digits_lo),
        .digits_hi    (digits_hi),
        .out_valid    (txt.valid),
        .out_ready    (txt.ready),
        .text_char    (txt.text_char),
        .last_char    (txt.last_char)
    );

endmodule

[rtl/core/srt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// srt_cfg_regs
// Configuration registers: radix and the two digit alphabet words. The radix
// is saturated into the supported range before use.
// ----------------------------------------------------------------------------
module srt_cfg_regs
    import srt_pkg::*;
#(
    parameter int MAX_RADIX = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output logic [$clog2(MAX_RADIX):0] active_radix,
    output logic [CFG_DATA_W-1:0] digits_lo,
    output logic [CFG_DATA_W-1:0] digits_hi
);
    localparam int RAD_W = $clog2(MAX_RADIX) + 1;

    logic [RADIX_W-1:0]    radix_reg;
    logic [CFG_DATA_W-1:0] digits_lo_reg;
    logic [CFG_DATA_W-1:0] digits_hi_reg;

    assign wr_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RESET;
            digits_lo_reg <= '0;
            digits_hi_reg <= '0;
        end
        else if (wr_valid)
        begin
            case (wr_index)
                REG_RADIX:     radix_reg     <= wr_data[RADIX_W-1:0];
                REG_DIGITS_LO: digits_lo_reg <= wr_data;
                REG_DIGITS_HI: digits_hi_reg <= wr_data;
                default:       ;
            endcase
        end
    end

    // Saturate the radix into 2..MAX_RADIX.
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            active_radix = RAD_W'(RADIX_MIN);
        end
        else if (radix_reg > RADIX_W'(MAX_RADIX))
        begin
            active_radix = RAD_W'(MAX_RADIX);
        end
        else
        begin
            active_radix = radix_reg[RAD_W-1:0];
        end
    end

    assign digits_lo = digits_lo_reg;
    assign digits_hi = digits_hi_reg;

endmodule

[rtl/core/srt_ctrl.sv]
// ----------------------------------------------------------------------------
// srt_ctrl
// Controller state machine: accepts a value, runs the divider until the
// quotient is zero, then sequences the sign and the digit characters.
// ----------------------------------------------------------------------------
module srt_ctrl
    import srt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  srt_stat_t stat,
    output srt_cmd_t  cmd
);
    srt_state_t state_reg;
    srt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (stat.step_last && stat.quot_zero)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = stat.neg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (stat.out_free && stat.ptr_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = stat.out_free;
            end
            ST_DIGITS:
            begin
                cmd.emit_digit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/srt_datapath.sv]
// ----------------------------------------------------------------------------
// srt_datapath
// Magnitude divider, digit store and output register. The divider shifts the
// magnitude through a register a byte per cycle and keeps a running
// remainder; the quotient fills the register from below.
// ----------------------------------------------------------------------------
module srt_datapath
    import srt_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_RADIX  = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  srt_cmd_t                     cmd,
    output srt_stat_t                    stat,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic [$clog2(MAX_RADIX):0]   active_radix,
    input  logic [CFG_DATA_W-1:0]        digits_lo,
    input  logic [CFG_DATA_W-1:0]        digits_hi,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [CHAR_W-1:0]            text_char,
    output logic                         last_char
);
    localparam int DIG_W    = $clog2(MAX_RADIX);
    localparam int RAD_W    = DIG_W + 1;
    localparam int DIV_CYC  = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int PAD_W    = DIV_CYC * DIV_STEP_BITS;
    localparam int CYC_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int ADDR_W   = $clog2(VALUE_BITS);
    localparam int CNT_W    = $clog2(VALUE_BITS + 1);

    logic [PAD_W-1:0]   shreg_reg;
    logic [PAD_W-1:0]   shreg_next;
    logic [DIG_W-1:0]   rem_reg;
    logic [DIG_W-1:0]   rem_next;
    logic [CYC_W-1:0]   cyc_reg;
    logic [CNT_W-1:0]   ndig_reg;
    logic [CNT_W-1:0]   ndig_m1;
    logic               neg_reg;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [ADDR_W-1:0]  ptr_next;
    logic [DIG_W-1:0]   digit_mem [VALUE_BITS];
    logic [DIG_W-1:0]   mem_q_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  text_char_reg;
    logic               last_char_reg;

    logic [VALUE_BITS-1:0]    mag;
    logic [DIV_STEP_BITS-1:0] qbyte;
    logic                     step_last;
    logic                     out_free;
    logic [DIGIT_CODE_W-1:0]  digit_code;
    logic [CFG_DATA_W-1:0]    alpha_word;
    logic [CHAR_W-1:0]        digit_char;

    // Magnitude of the two's complement input; the most negative value
    // gives 2^(VALUE_BITS-1), which still fits unsigned.
    assign mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

    // Restoring division of the top byte of the shift register, one bit at
    // a time, by the active radix.
    always_comb
    begin
        logic [DIG_W:0] t;
        logic [DIG_W-1:0] r;
        r     = rem_reg;
        qbyte = '0;
        for (int i = DIV_STEP_BITS - 1; i >= 0; i--)
        begin
            t = {r, shreg_reg[PAD_W - DIV_STEP_BITS + i]};
            if (t >= active_radix)
            begin
                t        = t - active_radix;
                qbyte[i] = 1'b1;
            end
            r = t[DIG_W-1:0];
        end
        rem_next   = r;
        shreg_next = (shreg_reg << DIV_STEP_BITS) | PAD_W'(qbyte);
    end

    assign step_last = (cyc_reg == CYC_W'(DIV_CYC - 1));
    assign ndig_m1   = ndig_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_reg  <= '0;
            ndig_reg <= '0;
            neg_reg  <= 1'b0;
            rem_reg  <= '0;
        end
        else if (cmd.load)
        begin
            cyc_reg  <= '0;
            ndig_reg <= '0;
            neg_reg  <= value[VALUE_BITS-1];
            rem_reg  <= '0;
        end
        else if (cmd.step)
        begin
            if (step_last)
            begin
                cyc_reg  <= '0;
                ndig_reg <= ndig_reg + CNT_W'(1);
                rem_reg  <= '0;
            end
            else
            begin
                cyc_reg <= cyc_reg + CYC_W'(1);
                rem_reg <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            shreg_reg <= PAD_W'(mag);
        end
        else if (cmd.step)
        begin
            shreg_reg <= shreg_next;
        end
    end

    // Digits are written lowest first and read back from the top down.
    always_ff @(posedge clk)
    begin
        if (cmd.step && step_last)
        begin
            digit_mem[ndig_reg[ADDR_W-1:0]] <= rem_next;
        end
        mem_q_reg <= digit_mem[ptr_next];
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.prep)
        begin
            ptr_next = ndig_m1[ADDR_W-1:0];
        end
        else if (cmd.emit_digit && (ptr_reg != '0))
        begin
            ptr_next = ptr_reg - ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // Alphabet lookup: digits 0..7 from the low word, 8..15 from the high.
    assign digit_code = DIGIT_CODE_W'(mem_q_reg);
    assign alpha_word = digit_code[DIGIT_CODE_W-1] ? digits_hi : digits_lo;
    assign digit_char = alpha_word[digit_code[DIGIT_CODE_W-2:0] * CHAR_W +: CHAR_W];

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            text_char_reg <= SIGN_CHAR;
            last_char_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            text_char_reg <= digit_char;
            last_char_reg <= (ptr_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign last_char = last_char_reg;

    assign stat.step_last = step_last;
    assign stat.quot_zero = (shreg_next == '0);
    assign stat.neg       = neg_reg;
    assign stat.ptr_zero  = (ptr_reg == '0);
    assign stat.out_free  = out_free;

endmodule
